// ===== hdl/jsd_pkg.sv =====
// Shared types and constants for the joystick eight-way direction decoder.
// No dependencies; every other file imports this package.
package jsd_pkg;

  // Field and datapath widths
  localparam int SampleW = 10;                  // axis sample and position width
  localparam int RegW    = 10;                  // configuration register width
  localparam int DiffW   = SampleW + 1;         // signed offset from the centre
  localparam int ProdW   = 2 * SampleW;         // one multiplier product
  localparam int DistW   = ProdW + 1;           // sum of two squares
  localparam int NumW    = 17;                  // |dy| * 100 fits here
  localparam int CntW    = $clog2(NumW);        // divider step counter
  localparam int ApbDataW = 32;
  localparam int ApbAddrW = 3;

  // Reset values of the registers and positions
  localparam logic [RegW-1:0] ResetCenter = RegW'(128);
  localparam logic [RegW-1:0] ResetRadius = RegW'(40);

  // Slope scale and thresholds
  localparam logic [SampleW-1:0] SlopeScale = SampleW'(100);
  localparam logic [NumW-1:0]    SlopeLow   = NumW'(25);
  localparam logic [NumW-1:0]    SlopeHigh  = NumW'(400);

  // Register indexes, taken from paddr[2]
  localparam logic RegCenter = 1'b0;
  localparam logic RegRadius = 1'b1;

  // Input commands
  typedef enum logic [1:0] {
    CMD_NONE = 2'd0,
    CMD_X    = 2'd1,
    CMD_Y    = 2'd2,
    CMD_SYNC = 2'd3
  } cmd_e;

  // Direction codes, centre is -1 in four bits
  typedef enum logic [3:0] {
    DIR_UP         = 4'd0,
    DIR_UP_LEFT    = 4'd1,
    DIR_LEFT       = 4'd2,
    DIR_DOWN_LEFT  = 4'd3,
    DIR_DOWN       = 4'd4,
    DIR_DOWN_RIGHT = 4'd5,
    DIR_RIGHT      = 4'd6,
    DIR_UP_RIGHT   = 4'd7,
    DIR_CENTRE     = 4'hF
  } dir_e;

  // Classifier sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ_X,
    ST_SQ_Y,
    ST_SQ_R,
    ST_SCALE,
    ST_CHECK,
    ST_DIV,
    ST_DECIDE,
    ST_DONE
  } cls_state_e;

  // Request into the classifier
  typedef struct packed {
    logic             start;
    logic [DiffW-1:0] dx;       // two's complement, latched_x - centre
    logic [DiffW-1:0] dy;       // two's complement, centre - latched_y
    logic [RegW-1:0]  radius;
  } cls_req_t;

  // Status out of the classifier
  typedef struct packed {
    logic busy;
    logic done;
    dir_e dir;
  } cls_stat_t;

endpackage

// ===== hdl/jsd_if.sv =====
// Handshake channels of the direction decoder: input events and result items.
// Depends on jsd_pkg for field widths.
interface jsd_in_if import jsd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic [SampleW-1:0] sample_value;

  modport source (output valid, output cmd, output sample_value, input ready);
  modport sink (input valid, input cmd, input sample_value, output ready);
endinterface

interface jsd_out_if import jsd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [SampleW-1:0] pos_x;
  logic [SampleW-1:0] pos_y;
  logic signed [3:0]  direction;
  logic               updated;

  modport source (output valid, output pos_x, output pos_y, output direction,
                  output updated, input ready);
  modport sink (input valid, input pos_x, input pos_y, input direction,
                input updated, output ready);
endinterface

// ===== hdl/jsd_classify.sv =====
// Sequenced direction classifier: one shared multiplier and a restoring divider.
// Depends on jsd_pkg for the request/status structs, states and direction codes.
module jsd_classify import jsd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cls_req_t  req_i,
  output cls_stat_t stat_o
);

  cls_state_e state_q, state_d;

  logic [SampleW-1:0] dxm_q, dym_q, r_q;
  logic               dxn_q, dyn_q;
  logic [ProdW-1:0]   prod_q;
  logic [DistW-1:0]   acc_q;
  logic [ProdW-1:0]   lim_q;
  logic [NumW-1:0]    num_q;
  logic [SampleW-1:0] rem_q;
  logic [CntW-1:0]    cnt_q;
  dir_e               dir_q;

  logic [SampleW-1:0] mul_a, mul_b;
  logic [ProdW-1:0]   mul_p;
  logic [DiffW-1:0]   dx_abs, dy_abs;
  logic               in_zone;
  logic               on_axis;
  logic [SampleW:0]   trial;
  logic [SampleW:0]   trial_diff;
  logic               trial_ge;

  // Decide by sign when one offset is zero
  function automatic dir_e axis_dir(logic [SampleW-1:0] xm, logic xn,
                                    logic [SampleW-1:0] ym, logic yn);
    dir_e d;
    if (xm != '0) begin
      d = xn ? DIR_LEFT : DIR_RIGHT;
    end else if (ym != '0) begin
      d = yn ? DIR_DOWN : DIR_UP;
    end else begin
      d = DIR_CENTRE;
    end
    return d;
  endfunction

  // Decide by slope magnitude and the signs of both offsets
  function automatic dir_e slope_dir(logic [NumW-1:0] q, logic xn, logic yn);
    dir_e lr;
    dir_e ud;
    dir_e d;
    lr = xn ? DIR_LEFT : DIR_RIGHT;
    ud = yn ? DIR_DOWN : DIR_UP;
    if (xn == yn) begin
      // slope is zero or positive
      if (q < SlopeLow) begin
        d = lr;
      end else if (q < SlopeHigh) begin
        d = xn ? DIR_DOWN_LEFT : DIR_UP_RIGHT;
      end else begin
        d = ud;
      end
    end else begin
      // slope is negative
      if (q <= SlopeLow) begin
        d = lr;
      end else if (q < SlopeHigh) begin
        d = xn ? DIR_UP_LEFT : DIR_DOWN_RIGHT;
      end else begin
        d = ud;
      end
    end
    return d;
  endfunction

  // Magnitudes of the incoming offsets
  assign dx_abs = req_i.dx[DiffW-1] ? (~req_i.dx + DiffW'(1)) : req_i.dx;
  assign dy_abs = req_i.dy[DiffW-1] ? (~req_i.dy + DiffW'(1)) : req_i.dy;

  // Shared multiplier
  assign mul_p = mul_a * mul_b;

  // Dead-zone and axis tests
  assign in_zone = acc_q < {1'b0, lim_q};
  assign on_axis = (dxm_q == '0) || (dym_q == '0);

  // One restoring divider step
  assign trial      = {rem_q, num_q[NumW-1]};
  assign trial_ge   = trial >= {1'b0, dxm_q};
  assign trial_diff = trial - {1'b0, dxm_q};

  // Sequencer state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and multiplier operand selection
  always_comb begin
    state_d = state_q;
    mul_a   = '0;
    mul_b   = '0;
    case (state_q)
      ST_IDLE: begin
        if (req_i.start) state_d = ST_SQ_X;
      end
      ST_SQ_X: begin
        mul_a   = dxm_q;
        mul_b   = dxm_q;
        state_d = ST_SQ_Y;
      end
      ST_SQ_Y: begin
        mul_a   = dym_q;
        mul_b   = dym_q;
        state_d = ST_SQ_R;
      end
      ST_SQ_R: begin
        mul_a   = r_q;
        mul_b   = r_q;
        state_d = ST_SCALE;
      end
      ST_SCALE: begin
        mul_a   = dym_q;
        mul_b   = SlopeScale;
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        state_d = (in_zone || on_axis) ? ST_DONE : ST_DIV;
      end
      ST_DIV: begin
        if (cnt_q == CntW'(NumW - 1)) state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Datapath: capture operands, accumulate squares, divide, decode
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (req_i.start) begin
          dxm_q <= dx_abs[SampleW-1:0];
          dxn_q <= req_i.dx[DiffW-1];
          dym_q <= dy_abs[SampleW-1:0];
          dyn_q <= req_i.dy[DiffW-1];
          r_q   <= req_i.radius;
        end
      end
      ST_SQ_X: begin
        prod_q <= mul_p;
      end
      ST_SQ_Y: begin
        acc_q  <= DistW'(prod_q);
        prod_q <= mul_p;
      end
      ST_SQ_R: begin
        acc_q  <= acc_q + DistW'(prod_q);
        prod_q <= mul_p;
      end
      ST_SCALE: begin
        lim_q  <= prod_q;
        prod_q <= mul_p;
      end
      ST_CHECK: begin
        num_q <= prod_q[NumW-1:0];
        rem_q <= '0;
        cnt_q <= '0;
        dir_q <= in_zone ? DIR_CENTRE : axis_dir(dxm_q, dxn_q, dym_q, dyn_q);
      end
      ST_DIV: begin
        rem_q <= trial_ge ? trial_diff[SampleW-1:0] : trial[SampleW-1:0];
        num_q <= {num_q[NumW-2:0], trial_ge};
        cnt_q <= cnt_q + CntW'(1);
      end
      ST_DECIDE: begin
        dir_q <= slope_dir(num_q, dxn_q, dyn_q);
      end
      default: begin
      end
    endcase
  end

  assign stat_o.busy = (state_q != ST_IDLE);
  assign stat_o.done = (state_q == ST_DONE);
  assign stat_o.dir  = dir_q;

endmodule

// ===== hdl/joystick_eight_way_direction.sv =====
// Top level of the joystick eight-way direction decoder: APB registers,
// sample capture, result register. Depends on jsd_pkg, jsd_if and jsd_classify.
//
// X and Y samples (cmd 1, 2) are stored as pending and ignored events (cmd 0)
// change nothing; both give a result item in the cycle after acceptance. A sync
// (cmd 3) latches the pending pair and classifies it into eight directions or
// centre. With a slope to divide out, the result follows four passes through
// the shared 10x10 multiplier, a dead-zone compare, 17 restoring divider
// steps, a decode, a hand-off and the result register; when the position
// lies in the dead zone or on an axis, the divider steps and decode are skipped.
// Input is taken only while no sync is in progress and the result register is
// free or being read.
// Registers: center_pos at byte address 0, dead_zone_radius at 4 (10 bits).
module joystick_eight_way_direction import jsd_pkg::*; #(
  parameter int unsigned AXIS_BITS = 10
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  jsd_in_if.sink              in_i,
  jsd_out_if.source           out_o
);

  localparam logic [SampleW-1:0] AxisMax =
    (AXIS_BITS >= SampleW) ? {SampleW{1'b1}} : SampleW'((1 << AXIS_BITS) - 1);

  logic [RegW-1:0]    center_q, radius_q;
  logic [SampleW-1:0] pend_x_q, pend_y_q, lat_x_q, lat_y_q;
  dir_e               cur_dir_q;
  logic               out_valid_q, out_upd_q;

  logic               cfg_wr;
  logic               in_acc;
  logic               is_sync;
  logic [SampleW-1:0] sample_sat;
  logic               load_out;
  cls_req_t           cls_req;
  cls_stat_t          cls_stat;

  // APB: always ready, write on the access phase
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    case (paddr[2])
      RegCenter: prdata = ApbDataW'(center_q);
      RegRadius: prdata = ApbDataW'(radius_q);
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_q <= ResetCenter;
      radius_q <= ResetRadius;
    end else if (cfg_wr) begin
      if (paddr[2] == RegCenter) center_q <= pwdata[RegW-1:0];
      if (paddr[2] == RegRadius) radius_q <= pwdata[RegW-1:0];
    end
  end

  // Accept an item when no sync is running and the result slot frees up
  assign in_i.ready = !cls_stat.busy && (!out_valid_q || out_o.ready);
  assign in_acc     = in_i.valid && in_i.ready;
  assign is_sync    = (in_i.cmd == CMD_SYNC);
  assign sample_sat = (in_i.sample_value > AxisMax) ? AxisMax : in_i.sample_value;

  // Hold pending samples, latch them on sync
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_x_q <= SampleW'(ResetCenter);
      pend_y_q <= SampleW'(ResetCenter);
      lat_x_q  <= SampleW'(ResetCenter);
      lat_y_q  <= SampleW'(ResetCenter);
    end else if (in_acc) begin
      case (in_i.cmd)
        CMD_X:    pend_x_q <= sample_sat;
        CMD_Y:    pend_y_q <= sample_sat;
        CMD_SYNC: begin
          lat_x_q <= pend_x_q;
          lat_y_q <= pend_y_q;
        end
        default: begin
        end
      endcase
    end
  end

  // Offsets from the centre, Y inverted so up is positive
  assign cls_req.start  = in_acc && is_sync;
  assign cls_req.dx     = DiffW'({1'b0, pend_x_q}) - DiffW'({1'b0, center_q});
  assign cls_req.dy     = DiffW'({1'b0, center_q}) - DiffW'({1'b0, pend_y_q});
  assign cls_req.radius = radius_q;

  jsd_classify u_classify (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (cls_req),
    .stat_o (cls_stat)
  );

  // Result register: load on a plain item or when classification finishes
  assign load_out = (in_acc && !is_sync) || cls_stat.done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_dir_q   <= DIR_CENTRE;
      out_valid_q <= 1'b0;
      out_upd_q   <= 1'b0;
    end else begin
      if (cls_stat.done) cur_dir_q <= cls_stat.dir;
      if (load_out) begin
        out_valid_q <= 1'b1;
        out_upd_q   <= cls_stat.done;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.pos_x     = lat_x_q;
  assign out_o.pos_y     = lat_y_q;
  assign out_o.direction = $signed(cur_dir_q);
  assign out_o.updated   = out_upd_q;

`ifndef NO_ASSERTIONS
  // A sync starts the classifier
  a_sync_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && is_sync) |=> cls_stat.busy)
    else $error("sync item did not start classification");

  // A finished classification never overwrites a pending result
  a_done_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cls_stat.done |-> !out_valid_q)
    else $error("classification finished while result slot occupied");

  // A plain item yields a result without the updated flag
  a_plain_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !is_sync) |=> (out_valid_q && !out_upd_q))
    else $error("plain item result missing or flagged updated");

  // A finished classification shows up as an updated result with its direction
  a_done_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cls_stat.done |=> (out_valid_q && out_upd_q && cur_dir_q == $past(cls_stat.dir)))
    else $error("classification result not presented");
`endif

endmodule
